@@ rtl/eos_pkg.sv @@
// Package for the elevator order scheduler: sizes, operation and direction
// codes, and the command bundle from the controller to the datapath.
// No dependencies.
package eos_pkg;

  // Table geometry
  localparam int FloorCount = 4;
  localparam int KindCount  = 3;
  localparam int TableW     = FloorCount * KindCount;
  localparam int FloorW     = (FloorCount > 1) ? $clog2(FloorCount) : 1;
  localparam int CntFullW   = $clog2(TableW + 1);

  // Port field widths
  localparam int OpW     = 2;
  localparam int BtnW    = 12;
  localparam int CurW    = 2;
  localparam int DirW    = 2;
  localparam int TargetW = 2;
  localparam int CountW  = 4;

  // Button kinds within a floor
  localparam int KindUp   = 0;
  localparam int KindDown = 1;
  localparam int KindCab  = 2;

  // Operation codes
  localparam logic [OpW-1:0] OpScan     = 2'd0;
  localparam logic [OpW-1:0] OpClearCur = 2'd1;
  localparam logic [OpW-1:0] OpResetAll = 2'd2;
  localparam logic [OpW-1:0] OpChoose   = 2'd3;

  // Direction codes (two's complement)
  localparam logic [DirW-1:0] DirNone = 2'b00;
  localparam logic [DirW-1:0] DirUp   = 2'b01;
  localparam logic [DirW-1:0] DirBad  = 2'b10;
  localparam logic [DirW-1:0] DirDown = 2'b11;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic execute;  // run the operation, load the result register
  } eos_cmd_t;

  // Buttons that physically exist: no bottom down call, no top up call
  function automatic logic [TableW-1:0] exist_mask();
    logic [TableW-1:0] m;
    m = '1;
    m[KindDown] = 1'b0;
    m[(FloorCount-1)*KindCount + KindUp] = 1'b0;
    return m;
  endfunction

endpackage

@@ rtl/eos_ctrl.sv @@
// Controller of the elevator order scheduler: request handshakes and the
// two-state sequence idle -> execute. Uses eos_pkg.
module eos_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output eos_pkg::eos_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, execute;

  // Handshakes
  assign accept  = in_valid_i && (state_q == StIdle);
  assign execute = (state_q == StExec) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = StExec;
      StExec: if (execute) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (execute) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = accept;
  assign cmd_o.execute = execute;

endmodule

@@ rtl/eos_datapath.sv @@
// Datapath of the elevator order scheduler: request register, order table,
// next target, scan/clear/choose logic and the result register. Uses eos_pkg.
module eos_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  eos_pkg::eos_cmd_t                  cmd_i,
  input  logic [eos_pkg::OpW-1:0]            operation_i,
  input  logic [eos_pkg::BtnW-1:0]           pressed_buttons_i,
  input  logic [eos_pkg::CurW-1:0]           car_floor_i,
  input  logic signed [eos_pkg::DirW-1:0]    moving_direction_i,
  input  logic signed [eos_pkg::DirW-1:0]    previous_direction_i,
  output logic                               found_o,
  output logic [eos_pkg::TargetW-1:0]        target_floor_o,
  output logic [eos_pkg::CountW-1:0]         order_count_o,
  output logic [eos_pkg::BtnW-1:0]           lamp_mask_o
);

  localparam int Fc = eos_pkg::FloorCount;
  localparam int Kc = eos_pkg::KindCount;
  localparam int Tw = eos_pkg::TableW;
  localparam int Fw = eos_pkg::FloorW;
  localparam logic [Tw-1:0] Exist = eos_pkg::exist_mask();
  localparam logic [Fw-1:0] TopFloor = Fw'(Fc - 1);

  // Request register
  logic [eos_pkg::OpW-1:0]  op_q;
  logic [eos_pkg::BtnW-1:0] pressed_q;
  logic [eos_pkg::CurW-1:0] cur_q;
  logic [eos_pkg::DirW-1:0] dir_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= operation_i;
      pressed_q <= pressed_buttons_i;
      cur_q     <= car_floor_i;
      dir_q     <= moving_direction_i;
      last_q    <= previous_direction_i;
    end
  end

  // Order table and target
  logic [Tw-1:0] pend_q, pend_d;
  logic [Fw-1:0] target_q, target_d;
  logic          found_d;

  // Saturate floor into range
  logic [Fw-1:0] cur;
  always_comb begin
    if ({{Fw{1'b0}}, cur_q} > {{eos_pkg::CurW{1'b0}}, TopFloor}) begin
      cur = TopFloor;
    end else begin
      cur = Fw'(cur_q);
    end
  end

  // Table occupancy: count, lowest and highest floors with an order
  logic [eos_pkg::CntFullW-1:0] cnt_now;
  logic [Fw-1:0]                any_lo_floor, any_hi_floor;
  logic                         any_order;
  always_comb begin
    cnt_now      = '0;
    any_lo_floor = '0;
    any_hi_floor = '0;
    any_order    = |pend_q;
    for (int b = 0; b < Tw; b++) begin
      cnt_now = cnt_now + eos_pkg::CntFullW'(pend_q[b]);
    end
    for (int f = Fc - 1; f >= 0; f--) begin
      if (|pend_q[f*Kc +: Kc]) any_lo_floor = Fw'(f);
    end
    for (int f = 0; f < Fc; f++) begin
      if (|pend_q[f*Kc +: Kc]) any_hi_floor = Fw'(f);
    end
  end

  // Button scan: first new press, and pending presses ahead of it
  logic [Tw-1:0] press, fresh, first_bit, below, seen_pending;
  logic [Fw-1:0] fresh_floor;
  always_comb begin
    press        = Tw'(pressed_q) & Exist;
    fresh        = press & ~pend_q;
    first_bit    = fresh & (~fresh + Tw'(1));
    below        = first_bit - Tw'(1);
    seen_pending = press & pend_q & below;
    fresh_floor  = '0;
    for (int f = 0; f < Fc; f++) begin
      if (|first_bit[f*Kc +: Kc]) fresh_floor = Fw'(f);
    end
  end

  // Choose: upward and downward candidates
  logic          up_hit, dn_hit;
  logic [Fw-1:0] up_floor, dn_floor;
  always_comb begin
    up_hit   = 1'b0;
    dn_hit   = 1'b0;
    up_floor = '0;
    dn_floor = '0;
    for (int f = Fc - 1; f >= 0; f--) begin
      if (Fw'(f) >= cur && (pend_q[f*Kc + eos_pkg::KindUp] ||
                            pend_q[f*Kc + eos_pkg::KindCab])) begin
        up_hit   = 1'b1;
        up_floor = Fw'(f);
      end
    end
    for (int f = 0; f < Fc; f++) begin
      if (Fw'(f) <= cur && (pend_q[f*Kc + eos_pkg::KindDown] ||
                            pend_q[f*Kc + eos_pkg::KindCab])) begin
        dn_hit   = 1'b1;
        dn_floor = Fw'(f);
      end
    end
  end

  // Direction priority
  logic go_up, go_dn;
  always_comb begin
    go_up = 1'b0;
    go_dn = 1'b0;
    case (dir_q)
      eos_pkg::DirUp:   go_up = 1'b1;
      eos_pkg::DirDown: go_dn = 1'b1;
      eos_pkg::DirNone: begin
        if (last_q == eos_pkg::DirUp) begin
          go_up = (cur != TopFloor);
          go_dn = (cur == TopFloor);
        end else if (last_q == eos_pkg::DirDown) begin
          go_dn = (cur != '0);
          go_up = (cur == '0);
        end
      end
      default: ;
    endcase
  end

  // Operation
  always_comb begin
    pend_d   = pend_q;
    target_d = target_q;
    found_d  = 1'b0;
    case (op_q)
      eos_pkg::OpScan: begin
        pend_d  = pend_q | first_bit;
        found_d = |fresh;
        if (cnt_now == '0 && (|fresh)) begin
          target_d = fresh_floor;
        end else if (cnt_now == eos_pkg::CntFullW'(1) && (|seen_pending)) begin
          target_d = any_lo_floor;
        end
      end
      eos_pkg::OpClearCur: begin
        for (int f = 0; f < Fc; f++) begin
          if (Fw'(f) == cur) pend_d[f*Kc +: Kc] = '0;
        end
      end
      eos_pkg::OpResetAll: pend_d = '0;
      eos_pkg::OpChoose: begin
        if (go_up) begin
          found_d = up_hit || any_order;
          if (up_hit) target_d = up_floor;
          else if (any_order) target_d = any_hi_floor;
        end else if (go_dn) begin
          found_d = dn_hit || any_order;
          if (dn_hit) target_d = dn_floor;
          else if (any_order) target_d = any_lo_floor;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      target_q <= '0;
    end else if (cmd_i.execute) begin
      pend_q   <= pend_d;
      target_q <= target_d;
    end
  end

  // Result fields from the updated table
  logic [eos_pkg::CntFullW-1:0] cnt_next;
  logic [eos_pkg::CountW-1:0]   cnt_sat;
  logic [eos_pkg::BtnW-1:0]     lamp_d;
  always_comb begin
    cnt_next = '0;
    lamp_d   = '0;
    for (int b = 0; b < Tw; b++) begin
      cnt_next = cnt_next + eos_pkg::CntFullW'(pend_d[b]);
    end
    for (int b = 0; b < eos_pkg::BtnW; b++) begin
      if (b < Tw) lamp_d[b] = pend_d[b];
    end
    if ({{eos_pkg::CountW{1'b0}}, cnt_next} >
        {{eos_pkg::CntFullW{1'b0}}, eos_pkg::CountMax}) begin
      cnt_sat = eos_pkg::CountMax;
    end else begin
      cnt_sat = eos_pkg::CountW'(cnt_next);
    end
  end

  // Result register
  logic                        found_q;
  logic [eos_pkg::TargetW-1:0] tgt_out_q;
  logic [eos_pkg::CountW-1:0]  count_q;
  logic [eos_pkg::BtnW-1:0]    lamp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      found_q   <= found_d;
      tgt_out_q <= eos_pkg::TargetW'(target_d);
      count_q   <= cnt_sat;
      lamp_q    <= lamp_d;
    end
  end

  assign found_o        = found_q;
  assign target_floor_o = tgt_out_q;
  assign order_count_o  = count_q;
  assign lamp_mask_o    = lamp_q;

endmodule

@@ rtl/elevator_order_scheduler_core.sv @@
// Channel   | Direction | Handshake            | Payload
// request   | in        | in_valid_i/in_stall_o   | operation, pressed_buttons,
//           |           |                         | car_floor, moving/previous_direction
// result    | out       | out_valid_o/out_stall_i | found, target_floor, order_count,
//           |           |                         | lamp_mask
//
// Each request is latched when it is taken; in the execute state the operation
// then runs on the order table and loads the result register. The next request
// is taken while a result still waits; its execute step waits for the result
// register. Reset (rst_ni, asynchronous) clears the order table, the target and
// both handshakes. A stalled result holds its payload.
// Top level of the elevator order scheduler; uses eos_pkg, eos_ctrl, eos_datapath.
module elevator_order_scheduler_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [eos_pkg::OpW-1:0]         operation_i,
  input  logic [eos_pkg::BtnW-1:0]        pressed_buttons_i,
  input  logic [eos_pkg::CurW-1:0]        car_floor_i,
  input  logic signed [eos_pkg::DirW-1:0] moving_direction_i,
  input  logic signed [eos_pkg::DirW-1:0] previous_direction_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [eos_pkg::TargetW-1:0]     target_floor_o,
  output logic [eos_pkg::CountW-1:0]      order_count_o,
  output logic [eos_pkg::BtnW-1:0]        lamp_mask_o
);

  eos_pkg::eos_cmd_t cmd;

  // Sequencing and handshakes
  eos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Order table and result
  eos_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .operation_i          (operation_i),
    .pressed_buttons_i    (pressed_buttons_i),
    .car_floor_i          (car_floor_i),
    .moving_direction_i   (moving_direction_i),
    .previous_direction_i (previous_direction_i),
    .found_o              (found_o),
    .target_floor_o       (target_floor_o),
    .order_count_o        (order_count_o),
    .lamp_mask_o          (lamp_mask_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for elevator_order_scheduler_core: drives a table of directed requests
// and then random trips, and checks every result against an order-table model kept here or
// against the result written into its table row. Depends on eos_pkg and the core RTL only.
module tb_top;
  import eos_pkg::*;

  localparam int QuietLimit = 5000;  // cycles without any handshake before giving up
  localparam int DrainTail  = 10;    // settle cycles after the last result

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [BtnW-1:0] btn;
    logic [CurW-1:0] cur;
    logic [DirW-1:0] dir;
    logic [DirW-1:0] last;
  } sched_req_t;

  typedef struct packed {
    logic               found;
    logic [TargetW-1:0] target;
    logic [CountW-1:0]  count;
    logic [BtnW-1:0]    lamps;
  } sched_res_t;

  typedef struct packed {
    sched_req_t req;
    logic       typed;  // result written into the row rather than predicted
    sched_res_t res;
  } sched_row_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_stall_o;
  logic [OpW-1:0] operation_i;
  logic [BtnW-1:0] pressed_buttons_i;
  logic [CurW-1:0] car_floor_i;
  logic signed [DirW-1:0] moving_direction_i, previous_direction_i;
  logic out_valid_o, out_stall_i;
  logic found_o;
  logic [TargetW-1:0] target_floor_o;
  logic [CountW-1:0] order_count_o;
  logic [BtnW-1:0] lamp_mask_o;

  // Model state: pending calls per floor (bit 0 up, 1 down, 2 cab) and the target
  logic [KindCount-1:0] order_tab [FloorCount];
  logic [TargetW-1:0]   goal_floor;

  sched_res_t due_results [$];
  sched_row_t dir_rows [$];
  int mismatches = 0;
  int reqs_sent = 0;
  int results_seen = 0;
  int found_seen = 0;
  int op_seen [4] = '{0, 0, 0, 0};
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet = 0;

  elevator_order_scheduler_core dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .pressed_buttons_i   (pressed_buttons_i),
    .car_floor_i         (car_floor_i),
    .moving_direction_i  (moving_direction_i),
    .previous_direction_i(previous_direction_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .found_o             (found_o),
    .target_floor_o      (target_floor_o),
    .order_count_o       (order_count_o),
    .lamp_mask_o         (lamp_mask_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic int count_pending();
    int n;
    n = 0;
    for (int f = 0; f < FloorCount; f++)
      for (int k = 0; k < KindCount; k++) n += order_tab[f][k];
    return n;
  endfunction

  // Own direction first (up or cab calls from here upwards), then top-down sweep
  function automatic logic pick_upward(int cur);
    logic hit;
    hit = 1'b0;
    for (int f = cur; f < FloorCount; f++)
      if (!hit && (order_tab[f][KindUp] || order_tab[f][KindCab])) begin
        goal_floor = TargetW'(f);
        hit = 1'b1;
      end
    for (int f = FloorCount - 1; f >= 0; f--)
      if (!hit && order_tab[f] != '0) begin
        goal_floor = TargetW'(f);
        hit = 1'b1;
      end
    return hit;
  endfunction

  // Down or cab calls from here downwards, then bottom-up sweep
  function automatic logic pick_downward(int cur);
    logic hit;
    hit = 1'b0;
    for (int f = cur; f >= 0; f--)
      if (!hit && (order_tab[f][KindDown] || order_tab[f][KindCab])) begin
        goal_floor = TargetW'(f);
        hit = 1'b1;
      end
    for (int f = 0; f < FloorCount; f++)
      if (!hit && order_tab[f] != '0) begin
        goal_floor = TargetW'(f);
        hit = 1'b1;
      end
    return hit;
  endfunction

  // Apply one request to the model and return the result it should produce
  function automatic sched_res_t step_order_table(sched_req_t r);
    sched_res_t res;
    logic hit;
    int cur, n;
    hit = 1'b0;
    cur = int'(r.cur);
    if (cur > FloorCount - 1) cur = FloorCount - 1;
    case (r.op)
      OpScan: begin
        // bottom to top, up/down/cab; missing buttons never count
        for (int f = 0; f < FloorCount; f++)
          for (int k = 0; k < KindCount; k++)
            if (!hit && r.btn[f*KindCount + k] &&
                !(f == 0 && k == KindDown) && !(f == FloorCount - 1 && k == KindUp)) begin
              if (!order_tab[f][k]) begin
                order_tab[f][k] = 1'b1;
                hit = 1'b1;
              end
              if (count_pending() == 1) goal_floor = TargetW'(f);
            end
      end
      OpClearCur: order_tab[cur] = '0;
      OpResetAll: for (int f = 0; f < FloorCount; f++) order_tab[f] = '0;
      default: begin
        case (r.dir)
          DirUp:   hit = pick_upward(cur);
          DirDown: hit = pick_downward(cur);
          DirNone: begin
            if (r.last == DirUp)
              hit = (cur != FloorCount - 1) ? pick_upward(cur) : pick_downward(cur);
            else if (r.last == DirDown)
              hit = (cur != 0) ? pick_downward(cur) : pick_upward(cur);
          end
          default: hit = 1'b0;
        endcase
      end
    endcase
    n = count_pending();
    res.found  = hit;
    res.target = goal_floor;
    res.count  = (n > 15) ? CountMax : CountW'(n);
    for (int f = 0; f < FloorCount; f++) res.lamps[f*KindCount +: KindCount] = order_tab[f];
    return res;
  endfunction

  // ---------------------------------------------------------------- request side
  function automatic sched_req_t mk_req(logic [OpW-1:0] op, logic [BtnW-1:0] btn,
                                        logic [CurW-1:0] cur, logic [DirW-1:0] dir,
                                        logic [DirW-1:0] last);
    sched_req_t r;
    r.op = op;
    r.btn = btn;
    r.cur = cur;
    r.dir = dir;
    r.last = last;
    return r;
  endfunction

  function automatic sched_row_t pred_row(sched_req_t r);
    sched_row_t row;
    row.req = r;
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic sched_row_t typed_row(sched_req_t r, logic found, logic [TargetW-1:0] tgt,
                                           logic [CountW-1:0] cnt, logic [BtnW-1:0] lamps);
    sched_row_t row;
    row.req = r;
    row.typed = 1'b1;
    row.res = '{found, tgt, cnt, lamps};
    return row;
  endfunction

  // Present one request after a random gap, hold it until taken, log its result
  task automatic issue(sched_row_t row);
    sched_res_t pred;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i           <= 1'b1;
    operation_i          <= row.req.op;
    pressed_buttons_i    <= row.req.btn;
    car_floor_i          <= row.req.cur;
    moving_direction_i   <= row.req.dir;
    previous_direction_i <= row.req.last;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    pred = step_order_table(row.req);
    due_results.push_back(row.typed ? row.res : pred);
    reqs_sent++;
    op_seen[row.req.op]++;
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // Mostly trips (calls, a choice, arrival at the target), plus noise and full resets
  task automatic run_random(int goal);
    int pick, nscan;
    logic [BtnW-1:0] btn;
    logic [DirW-1:0] dir, last;
    while (reqs_sent < goal) begin
      pick = $urandom_range(99, 0);
      if (pick < 75) begin
        nscan = $urandom_range(3, 1);
        for (int i = 0; i < nscan; i++) begin
          btn = BtnW'(1) << $urandom_range(BtnW - 1, 0);
          if ($urandom_range(3, 0) == 0) btn |= BtnW'(1) << $urandom_range(BtnW - 1, 0);
          issue(pred_row(mk_req(OpScan, btn, CurW'($urandom_range(3, 0)),
                                DirW'($urandom_range(3, 0)), DirW'($urandom_range(3, 0)))));
        end
        last = $urandom_range(1, 0) ? DirUp : DirDown;
        case ($urandom_range(3, 0))
          0:       dir = DirUp;
          1:       dir = DirDown;
          default: dir = DirNone;
        endcase
        issue(pred_row(mk_req(OpChoose, BtnW'($urandom), CurW'($urandom_range(3, 0)),
                              dir, last)));
        issue(pred_row(mk_req(OpClearCur, BtnW'($urandom), goal_floor,
                              DirW'($urandom_range(3, 0)), DirW'($urandom_range(3, 0)))));
      end else if (pick < 80) begin
        issue(pred_row(mk_req(OpResetAll, BtnW'($urandom), CurW'($urandom_range(3, 0)),
                              DirW'($urandom_range(3, 0)), DirW'($urandom_range(3, 0)))));
      end else begin
        issue(pred_row(mk_req(OpW'($urandom_range(3, 0)), BtnW'($urandom),
                              CurW'($urandom_range(3, 0)), DirW'($urandom_range(3, 0)),
                              DirW'($urandom_range(3, 0)))));
      end
    end
  endtask

  // ---------------------------------------------------------------- result side
  always @(negedge clk) out_stall_i <= ($urandom_range(99, 0) < rx_idle_pct);

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{found_o, target_floor_o, order_count_o, lamp_mask_o};
      results_seen++;
      if (found_o) found_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: found %0b target %0d count %0d lamps %03h",
                   $realtime, got.found, got.target, got.count, got.lamps);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] #%0d exp/act: found %0b/%0b tgt %0d/%0d cnt %0d/%0d lamps %03h/%03h",
                     $realtime, results_seen, want.found, got.found, want.target, got.target,
                     want.count, got.count, want.lamps, got.lamps);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("watchdog expired: %0d requests sent, %0d results outstanding",
                 reqs_sent, due_results.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OpScan;
    pressed_buttons_i = '0;
    car_floor_i = '0;
    moving_direction_i = DirNone;
    previous_direction_i = DirNone;
    for (int f = 0; f < FloorCount; f++) order_tab[f] = '0;
    goal_floor = '0;

    // directed: empty table, missing buttons, fill to all ten calls, each choice rule
    dir_rows.push_back(typed_row(mk_req(OpChoose, 12'h000, 2'd0, DirUp, DirNone),
                                 1'b0, 2'd0, 4'd0, 12'h000));
    dir_rows.push_back(typed_row(mk_req(OpScan, 12'hFFF, 2'd0, DirNone, DirNone),
                                 1'b1, 2'd0, 4'd1, 12'h001));
    dir_rows.push_back(typed_row(mk_req(OpScan, 12'h202, 2'd3, DirBad, DirBad),
                                 1'b0, 2'd0, 4'd1, 12'h001));
    dir_rows.push_back(typed_row(mk_req(OpScan, 12'h000, 2'd1, DirDown, DirUp),
                                 1'b0, 2'd0, 4'd1, 12'h001));
    dir_rows.push_back(pred_row(mk_req(OpScan, 12'h800, 2'd2, DirUp, DirDown)));
    for (int i = 0; i < 8; i++)
      dir_rows.push_back(pred_row(mk_req(OpScan, 12'hFFF, 2'd0, DirNone, DirNone)));
    dir_rows.push_back(typed_row(mk_req(OpScan, 12'hFFF, 2'd3, DirNone, DirNone),
                                 1'b0, 2'd0, 4'd10, 12'hDFD));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'h000, 2'd1, DirUp, DirNone)));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'h000, 2'd2, DirDown, DirUp)));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'h000, 2'd3, DirNone, DirUp)));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'h000, 2'd0, DirNone, DirDown)));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'hFFF, 2'd1, DirBad, DirUp)));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'h000, 2'd2, DirNone, DirNone)));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'h000, 2'd1, DirNone, DirBad)));
    dir_rows.push_back(pred_row(mk_req(OpClearCur, 12'hFFF, 2'd3, DirDown, DirDown)));
    dir_rows.push_back(pred_row(mk_req(OpClearCur, 12'h000, 2'd0, DirUp, DirUp)));
    dir_rows.push_back(pred_row(mk_req(OpResetAll, 12'hFFF, 2'd2, DirBad, DirBad)));
    dir_rows.push_back(pred_row(mk_req(OpChoose, 12'h000, 2'd2, DirDown, DirNone)));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // sender idles 20 %, receiver 59 %; a full drain part-way through
    tx_idle_pct = 20;
    rx_idle_pct = 59;
    foreach (dir_rows[i]) issue(dir_rows[i]);
    run_random(310);
    drain();
    run_random(600);
    drain();

    // the other way round
    tx_idle_pct = 59;
    rx_idle_pct = 20;
    run_random(1175);
    drain();

    // back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(1750);
    drain();
    repeat (DrainTail) @(negedge clk);

    $display("Ran %0d requests: %0d scans, %0d floor clears, %0d full resets, %0d choices.",
             reqs_sent, op_seen[OpScan], op_seen[OpClearCur], op_seen[OpResetAll],
             op_seen[OpChoose]);
    $display("Checked %0d results (%0d with found set) under three idling mixes; %0d mismatches.",
             results_seen, found_seen, mismatches);
    if (mismatches == 0 && due_results.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ elevator_order_scheduler_core.f @@
rtl/eos_pkg.sv
rtl/eos_ctrl.sv
rtl/eos_datapath.sv
rtl/elevator_order_scheduler_core.sv
tb/tb_top.sv
